// ----- rtl/ingress_outstanding_limiter_assert.svh -----
// ----------------------------------------------------------------------------
// ingress outstanding limiter assertion macros
// shared property forms used by iol_back
// ----------------------------------------------------------------------------
`ifndef INGRESS_OUTSTANDING_LIMITER_ASSERT_SVH
`define INGRESS_OUTSTANDING_LIMITER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define IOL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define IOL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/iol_pkg.sv -----
// ----------------------------------------------------------------------------
// iol_pkg
// shared types and constants of the ingress outstanding limiter
// ----------------------------------------------------------------------------
package iol_pkg;

    // raw command codes on the input stream
    localparam logic [2:0] CMD_REQ_IN    = 3'd0;
    localparam logic [2:0] CMD_REQ_FWD   = 3'd1;
    localparam logic [2:0] CMD_REQ_RETRY = 3'd2;
    localparam logic [2:0] CMD_RSP_IN    = 3'd3;
    localparam logic [2:0] CMD_RSP_FWD   = 3'd4;
    localparam logic [2:0] CMD_RSP_RETRY = 3'd5;

    // configuration register indexes
    localparam logic CFG_LIMIT = 1'b0;
    localparam logic CFG_DEPTH = 1'b1;

    // configuration widths and reset values
    localparam int LIMIT_W = 8;
    localparam int DEPTH_W = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd16;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd16;

    // fifo fill counts never exceed the usable depth register range
    localparam int FILL_W = 5;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_NOP,
        OP_REQ_IN,
        OP_REQ_FWD,
        OP_REQ_RETRY,
        OP_RSP_IN,
        OP_RSP_FWD,
        OP_RSP_RETRY
    } t_op;

    typedef struct packed {
        t_op  op;
        logic partner_ready;
    } t_event_ctl;

    // flag and fill part of one result item
    typedef struct packed {
        logic              accepted;
        logic              fwd_valid;
        logic              fwd_dir;
        logic              retry_up;
        logic              unmatched;
        logic [FILL_W-1:0] req_fill;
        logic [FILL_W-1:0] rsp_fill;
    } t_result;

    // execution sequencer states
    typedef enum logic {
        BS_EXEC,
        BS_FETCH
    } t_bstate;

endpackage

// ----- rtl/ingress_outstanding_limiter.sv -----
// a result item is registered once its item has passed the two-entry input queue;
// an item that forwards a fifo head also passes the tag fetch state (registered
// tag memory read); one item per cycle while the output is free and no fetch runs
// reset: synchronous active low; clears queue, counts, flags and fifo pointers,
// sets outstanding_limit and buffer_depth_in_use to 16; tag storage is not cleared
// ----------------------------------------------------------------------------
// ingress_outstanding_limiter
// caps outstanding requests and buffers request and response tags with retry
// ----------------------------------------------------------------------------
module ingress_outstanding_limiter #(
    parameter int FIFO_DEPTH  = 16,
    parameter int TAG_WIDTH   = 16,
    parameter int COUNT_WIDTH = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [iol_pkg::LIMIT_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // fields from bit 0: packet_tag, partner_ready, zero pad
    input  logic [((TAG_WIDTH+1+7)/8)*8-1:0] i_s_axis_tdata,
    // fields from bit 0: cmd
    input  logic [2:0]                  i_s_axis_tuser,
    // result stream
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // fields from bit 0: accepted, forward_valid, forward_tag, retry_upstream,
    // unmatched_response, outstanding_now, request_fill, response_fill, zero pad
    output logic [((TAG_WIDTH+COUNT_WIDTH+14+7)/8)*8-1:0] o_m_axis_tdata,
    // fields from bit 0: forward_direction
    output logic [0:0]                  o_m_axis_tuser
);

    localparam int OUT_RAW_W = TAG_WIDTH + COUNT_WIDTH + 14;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    logic                   q_valid;
    logic                   q_ready;
    iol_pkg::t_event_ctl    q_ctl;
    logic [TAG_WIDTH-1:0]   q_tag;
    iol_pkg::t_result       out_res;
    logic [TAG_WIDTH-1:0]   out_tag;
    logic [COUNT_WIDTH-1:0] out_count;
    logic [OUT_RAW_W-1:0]   out_raw;

    iol_front #(
        .TAG_WIDTH (TAG_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_axis_tvalid),
        .o_ready         (o_s_axis_tready),
        .i_cmd           (i_s_axis_tuser),
        .i_tag           (i_s_axis_tdata[TAG_WIDTH-1:0]),
        .i_partner_ready (i_s_axis_tdata[TAG_WIDTH]),
        .o_q_valid       (q_valid),
        .i_q_ready       (q_ready),
        .o_q_ctl         (q_ctl),
        .o_q_tag         (q_tag)
    );

    iol_back #(
        .FIFO_DEPTH  (FIFO_DEPTH),
        .TAG_WIDTH   (TAG_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_ctl     (q_ctl),
        .i_q_tag     (q_tag),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_res   (out_res),
        .o_out_tag   (out_tag),
        .o_out_count (out_count)
    );

    // result packing, first field in the low bits
    assign out_raw = {out_res.rsp_fill, out_res.req_fill, out_count, out_res.unmatched,
                      out_res.retry_up, out_tag, out_res.fwd_valid, out_res.accepted};
    assign o_m_axis_tdata    = OUT_W'(out_raw);
    assign o_m_axis_tuser[0] = out_res.fwd_dir;

endmodule

// ----- rtl/iol_front.sv -----
// ----------------------------------------------------------------------------
// iol_front
// accepts input items, classifies the command and queues them for the back
// ----------------------------------------------------------------------------
module iol_front #(
    parameter int TAG_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_cmd,
    input  logic [TAG_WIDTH-1:0] i_tag,
    input  logic                 i_partner_ready,
    output logic                 o_q_valid,
    input  logic                 i_q_ready,
    output iol_pkg::t_event_ctl  o_q_ctl,
    output logic [TAG_WIDTH-1:0] o_q_tag
);

    iol_pkg::t_event_ctl  r_q_ctl [2];
    logic [TAG_WIDTH-1:0] r_q_tag [2];
    logic                 r_wr_ptr;
    logic                 r_rd_ptr;
    logic [1:0]           r_cnt;
    logic [1:0]           n_cnt;
    iol_pkg::t_event_ctl  dec_ctl;
    logic                 push;
    logic                 pop;

    // command classification
    always_comb begin
        dec_ctl.partner_ready = i_partner_ready;
        unique case (i_cmd)
            iol_pkg::CMD_REQ_IN:    dec_ctl.op = iol_pkg::OP_REQ_IN;
            iol_pkg::CMD_REQ_FWD:   dec_ctl.op = iol_pkg::OP_REQ_FWD;
            iol_pkg::CMD_REQ_RETRY: dec_ctl.op = iol_pkg::OP_REQ_RETRY;
            iol_pkg::CMD_RSP_IN:    dec_ctl.op = iol_pkg::OP_RSP_IN;
            iol_pkg::CMD_RSP_FWD:   dec_ctl.op = iol_pkg::OP_RSP_FWD;
            iol_pkg::CMD_RSP_RETRY: dec_ctl.op = iol_pkg::OP_RSP_RETRY;
            default:                dec_ctl.op = iol_pkg::OP_NOP;
        endcase
    end

    // two-entry queue handshake
    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign push      = i_valid && o_ready;
    assign pop       = o_q_valid && i_q_ready;
    assign o_q_ctl   = r_q_ctl[r_rd_ptr];
    assign o_q_tag   = r_q_tag[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // queue pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_ctl[r_wr_ptr] <= dec_ctl;
            r_q_tag[r_wr_ptr] <= i_tag;
        end
    end

endmodule

// ----- rtl/iol_tag_fifo.sv -----
// ----------------------------------------------------------------------------
// iol_tag_fifo
// circular tag store with fill count and registered head read
// ----------------------------------------------------------------------------
module iol_tag_fifo #(
    parameter int FIFO_DEPTH = 16,
    parameter int TAG_WIDTH  = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [TAG_WIDTH-1:0]       i_push_tag,
    input  logic                       i_pop,
    output logic [iol_pkg::FILL_W-1:0] o_fill,
    output logic [TAG_WIDTH-1:0]       o_pop_tag
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    logic [TAG_WIDTH-1:0]       r_mem [FIFO_DEPTH];
    logic [TAG_WIDTH-1:0]       r_rd_data;
    logic [PTR_W-1:0]           r_head;
    logic [PTR_W-1:0]           r_tail;
    logic [iol_pkg::FILL_W-1:0] r_fill;

    assign o_fill    = r_fill;
    assign o_pop_tag = r_rd_data;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_tail <= (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
            end
            if (i_pop) begin
                r_head <= (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // storage write and registered head read
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_push_tag;
        end
        if (i_pop) begin
            r_rd_data <= r_mem[r_head];
        end
    end

endmodule

// ----- rtl/iol_back.sv -----
// ----------------------------------------------------------------------------
// iol_back
// executes queued items against the limiter state and holds the result item
// ----------------------------------------------------------------------------
`include "ingress_outstanding_limiter_assert.svh"

module iol_back #(
    parameter int FIFO_DEPTH  = 16,
    parameter int TAG_WIDTH   = 16,
    parameter int COUNT_WIDTH = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [iol_pkg::LIMIT_W-1:0] i_cfg_wdata,
    input  logic                        i_q_valid,
    output logic                        o_q_ready,
    input  iol_pkg::t_event_ctl         i_q_ctl,
    input  logic [TAG_WIDTH-1:0]        i_q_tag,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output iol_pkg::t_result            o_out_res,
    output logic [TAG_WIDTH-1:0]        o_out_tag,
    output logic [COUNT_WIDTH-1:0]      o_out_count
);

    localparam int CAP_INT = (FIFO_DEPTH > 31) ? 31 : FIFO_DEPTH;
    localparam logic [iol_pkg::FILL_W-1:0] DEPTH_CAP = iol_pkg::FILL_W'(CAP_INT);
    localparam int CMP_W = (COUNT_WIDTH > iol_pkg::LIMIT_W) ? COUNT_WIDTH : iol_pkg::LIMIT_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // configuration and limiter state
    logic [iol_pkg::LIMIT_W-1:0] r_cfg_limit;
    logic [iol_pkg::DEPTH_W-1:0] r_cfg_depth;
    logic [COUNT_WIDTH-1:0]      r_count;
    logic [COUNT_WIDTH-1:0]      n_count;
    logic                        r_retry_owed;
    logic                        n_retry_owed;
    logic                        r_ds_wait;
    logic                        n_ds_wait;
    logic                        r_us_wait;
    logic                        n_us_wait;
    iol_pkg::t_bstate            r_state;
    iol_pkg::t_bstate            n_state;

    // result holding
    logic                        r_out_valid;
    iol_pkg::t_result            r_out_res;
    logic [TAG_WIDTH-1:0]        r_out_tag;
    logic [COUNT_WIDTH-1:0]      r_out_count;
    iol_pkg::t_result            r_pend_res;
    logic [COUNT_WIDTH-1:0]      r_pend_count;

    // step signals
    logic                        take;
    logic                        out_free;
    logic                        load_direct;
    logic                        load_fetch;
    logic                        req_push;
    logic                        rsp_push;
    logic                        req_pop;
    logic                        rsp_pop;
    logic                        req_room;
    logic                        room_after;
    logic [iol_pkg::FILL_W-1:0]  usable;
    logic [iol_pkg::FILL_W-1:0]  req_fill;
    logic [iol_pkg::FILL_W-1:0]  rsp_fill;
    logic [iol_pkg::FILL_W-1:0]  req_fill_after_pop;
    logic [TAG_WIDTH-1:0]        req_pop_tag;
    logic [TAG_WIDTH-1:0]        rsp_pop_tag;
    iol_pkg::t_result            res;

    iol_tag_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .TAG_WIDTH  (TAG_WIDTH)
    ) u_req_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (req_push),
        .i_push_tag (i_q_tag),
        .i_pop      (req_pop),
        .o_fill     (req_fill),
        .o_pop_tag  (req_pop_tag)
    );

    iol_tag_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .TAG_WIDTH  (TAG_WIDTH)
    ) u_rsp_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (rsp_push),
        .i_push_tag (i_q_tag),
        .i_pop      (rsp_pop),
        .o_fill     (rsp_fill),
        .o_pop_tag  (rsp_pop_tag)
    );

    // handshake toward the queue and the output
    assign out_free  = !r_out_valid || i_out_ready;
    assign take      = i_q_valid && out_free && (r_state == iol_pkg::BS_EXEC);
    assign o_q_ready = out_free && (r_state == iol_pkg::BS_EXEC);

    // usable depth and request admission
    assign usable   = (r_cfg_depth > DEPTH_CAP) ? DEPTH_CAP : r_cfg_depth;
    assign req_room = (CMP_W'(r_count) < CMP_W'(r_cfg_limit)) && (r_count != COUNT_MAX) &&
                      (req_fill < usable);
    assign req_fill_after_pop = req_pop ? req_fill - 1'b1 : req_fill;
    assign room_after = (CMP_W'(n_count) < CMP_W'(r_cfg_limit)) && (n_count != COUNT_MAX) &&
                        (req_fill_after_pop < usable);

    // item execution
    always_comb begin
        n_count      = r_count;
        n_retry_owed = r_retry_owed;
        n_ds_wait    = r_ds_wait;
        n_us_wait    = r_us_wait;
        req_push     = 1'b0;
        rsp_push     = 1'b0;
        req_pop      = 1'b0;
        rsp_pop      = 1'b0;
        res          = '0;
        if (take) begin
            case (i_q_ctl.op)
                iol_pkg::OP_REQ_IN: begin
                    if (req_room) begin
                        n_count      = r_count + 1'b1;
                        req_push     = 1'b1;
                        res.accepted = 1'b1;
                    end else begin
                        n_retry_owed = 1'b1;
                    end
                end
                iol_pkg::OP_REQ_FWD: begin
                    if (!r_ds_wait && (req_fill != '0)) begin
                        if (i_q_ctl.partner_ready) begin
                            req_pop       = 1'b1;
                            res.fwd_valid = 1'b1;
                        end else begin
                            n_ds_wait = 1'b1;
                        end
                    end
                end
                iol_pkg::OP_REQ_RETRY: n_ds_wait = 1'b0;
                iol_pkg::OP_RSP_IN: begin
                    if (rsp_fill < usable) begin
                        rsp_push     = 1'b1;
                        res.accepted = 1'b1;
                    end
                end
                iol_pkg::OP_RSP_FWD: begin
                    if (!r_us_wait && (rsp_fill != '0)) begin
                        if (i_q_ctl.partner_ready) begin
                            rsp_pop       = 1'b1;
                            res.fwd_valid = 1'b1;
                            res.fwd_dir   = 1'b1;
                            if (r_count == '0) begin
                                res.unmatched = 1'b1;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end else begin
                            n_us_wait = 1'b1;
                        end
                    end
                end
                iol_pkg::OP_RSP_RETRY: n_us_wait = 1'b0;
                default: ;
            endcase
            // owed retry goes out after a pop once a request would fit
            if ((req_pop || rsp_pop) && r_retry_owed && room_after) begin
                n_retry_owed = 1'b0;
                res.retry_up = 1'b1;
            end
        end
        res.req_fill = req_fill + iol_pkg::FILL_W'(req_push) - iol_pkg::FILL_W'(req_pop);
        res.rsp_fill = rsp_fill + iol_pkg::FILL_W'(rsp_push) - iol_pkg::FILL_W'(rsp_pop);
    end

    // sequencer next state: pops wait in the fetch state for the tag read
    always_comb begin
        n_state     = r_state;
        load_direct = 1'b0;
        load_fetch  = 1'b0;
        unique case (r_state)
            iol_pkg::BS_EXEC: begin
                if (take) begin
                    if (req_pop || rsp_pop) begin
                        n_state = iol_pkg::BS_FETCH;
                    end else begin
                        load_direct = 1'b1;
                    end
                end
            end
            iol_pkg::BS_FETCH: begin
                if (out_free) begin
                    load_fetch = 1'b1;
                    n_state    = iol_pkg::BS_EXEC;
                end
            end
            default: n_state = iol_pkg::BS_EXEC;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_limit  <= iol_pkg::LIMIT_RESET;
            r_cfg_depth  <= iol_pkg::DEPTH_RESET;
            r_count      <= '0;
            r_retry_owed <= 1'b0;
            r_ds_wait    <= 1'b0;
            r_us_wait    <= 1'b0;
            r_state      <= iol_pkg::BS_EXEC;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == iol_pkg::CFG_LIMIT) begin
                    r_cfg_limit <= i_cfg_wdata;
                end else begin
                    r_cfg_depth <= i_cfg_wdata[iol_pkg::DEPTH_W-1:0];
                end
            end
            r_count      <= n_count;
            r_retry_owed <= n_retry_owed;
            r_ds_wait    <= n_ds_wait;
            r_us_wait    <= n_us_wait;
            r_state      <= n_state;
            if (load_direct || load_fetch) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (take && (req_pop || rsp_pop)) begin
            r_pend_res   <= res;
            r_pend_count <= n_count;
        end
        if (load_direct) begin
            r_out_res   <= res;
            r_out_tag   <= '0;
            r_out_count <= n_count;
        end else if (load_fetch) begin
            r_out_res   <= r_pend_res;
            r_out_tag   <= r_pend_res.fwd_dir ? rsp_pop_tag : req_pop_tag;
            r_out_count <= r_pend_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;
    assign o_out_tag   = r_out_tag;
    assign o_out_count = r_out_count;

    // assertions
    `IOL_ASSERT_NXT(a_pop_fetch, i_clk, i_rst_n, take && (req_pop || rsp_pop), r_state == iol_pkg::BS_FETCH, "pop did not enter tag fetch")
    `IOL_ASSERT_IMP(a_fetch_pend, i_clk, i_rst_n, r_state == iol_pkg::BS_FETCH, r_pend_res.fwd_valid, "fetch without a pending forward")
    `IOL_ASSERT_IMP(a_unmatched_rsp, i_clk, i_rst_n, r_out_valid && r_out_res.unmatched, r_out_res.fwd_valid && r_out_res.fwd_dir, "unmatched flag without response forward")
    `IOL_ASSERT_IMP(a_retry_pop, i_clk, i_rst_n, r_out_valid && r_out_res.retry_up, r_out_res.fwd_valid, "retry signalled without a pop")

endmodule

// ----- tb/ingress_outstanding_limiter_tb.sv -----
// ----------------------------------------------------------------------------
// ingress_outstanding_limiter_tb
// streams request, response, forward and retry events into the limiter, runs a
// item-level model of counts, tag fifos and flags beside it, and checks every
// result item field by field across several register settings and idle modes
// ----------------------------------------------------------------------------
module ingress_outstanding_limiter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAG_W       = 16;
    localparam int COUNT_W     = 8;
    localparam int BUILT_DEPTH = 16;
    localparam int IN_DATA_W   = ((TAG_W + 1 + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((TAG_W + COUNT_W + 14 + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 8;

    // command codes the block ignores
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    typedef enum int {
        PH_DIRECTED,
        PH_RANDOM,
        PH_FILL,
        PH_SATURATE
    } t_phase_kind;

    typedef struct {
        logic [2:0]       cmd;
        logic [TAG_W-1:0] tag;
        logic             ready;
    } t_ingress_item;

    typedef struct {
        logic               accepted;
        logic               fwd_valid;
        logic               fwd_dir;
        logic [TAG_W-1:0]   fwd_tag;
        logic               retry_up;
        logic               unmatched;
        logic [COUNT_W-1:0] outstanding;
        logic [4:0]         req_fill;
        logic [4:0]         rsp_fill;
    } t_outcome;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic                          i_cfg_index = 1'b0;
    logic [iol_pkg::LIMIT_W-1:0]   i_cfg_wdata = '0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    // packet_tag, partner_ready, zero pad
    logic [IN_DATA_W-1:0]          i_s_axis_tdata = '0;
    // cmd
    logic [2:0]                    i_s_axis_tuser = '0;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    // accepted, forward_valid, forward_tag, retry_upstream, unmatched_response,
    // outstanding_now, request_fill, response_fill, zero pad
    logic [OUT_DATA_W-1:0]         o_m_axis_tdata;
    // forward_direction
    logic [0:0]                    o_m_axis_tuser;

    ingress_outstanding_limiter #(
        .FIFO_DEPTH  (BUILT_DEPTH),
        .TAG_WIDTH   (TAG_W),
        .COUNT_WIDTH (COUNT_W)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // stimulus and expectation stores
    t_ingress_item items_to_send[$];
    t_outcome      results_due[$];
    t_ingress_item cur_item;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int fail_count      = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int retries_seen    = 0;
    int unmatched_seen  = 0;
    int refusals_seen   = 0;
    int phases_run      = 0;

    // model state
    logic [iol_pkg::LIMIT_W-1:0] limit_reg;
    logic [iol_pkg::DEPTH_W-1:0] depth_reg;
    logic [COUNT_W-1:0]          outstanding;
    logic [TAG_W-1:0]            req_tags[$];
    logic [TAG_W-1:0]            rsp_tags[$];
    logic                        retry_owed;
    logic                        down_wait;
    logic                        up_wait;

    function automatic int usable_depth();
        return (depth_reg > BUILT_DEPTH) ? BUILT_DEPTH : int'(depth_reg);
    endfunction

    function automatic logic request_room();
        return (outstanding < limit_reg) && (outstanding != {COUNT_W{1'b1}}) &&
               (req_tags.size() < usable_depth());
    endfunction

    // owed retry goes upstream once a new request would be taken
    function automatic logic release_retry();
        if (retry_owed && request_room()) begin
            retry_owed = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void reset_limiter_state();
        limit_reg   = iol_pkg::LIMIT_RESET;
        depth_reg   = iol_pkg::DEPTH_RESET;
        outstanding = '0;
        req_tags.delete();
        rsp_tags.delete();
        retry_owed  = 1'b0;
        down_wait   = 1'b0;
        up_wait     = 1'b0;
    endfunction

    // apply one event to the model and return the result item it causes
    function automatic t_outcome limiter_outcome(t_ingress_item it);
        t_outcome r;
        r = '{default: '0};
        case (it.cmd)
            iol_pkg::CMD_REQ_IN: begin
                if (request_room()) begin
                    outstanding++;
                    req_tags.insert(req_tags.size(), it.tag);
                    r.accepted = 1'b1;
                end else begin
                    retry_owed = 1'b1;
                end
            end
            iol_pkg::CMD_REQ_FWD: begin
                if (!down_wait && req_tags.size() != 0) begin
                    if (it.ready) begin
                        r.fwd_tag   = req_tags[0];
                        req_tags.delete(0);
                        r.fwd_valid = 1'b1;
                        r.retry_up  = release_retry();
                    end else begin
                        down_wait = 1'b1;
                    end
                end
            end
            iol_pkg::CMD_REQ_RETRY: down_wait = 1'b0;
            iol_pkg::CMD_RSP_IN: begin
                if (rsp_tags.size() < usable_depth()) begin
                    rsp_tags.insert(rsp_tags.size(), it.tag);
                    r.accepted = 1'b1;
                end
            end
            iol_pkg::CMD_RSP_FWD: begin
                if (!up_wait && rsp_tags.size() != 0) begin
                    if (it.ready) begin
                        r.fwd_tag   = rsp_tags[0];
                        rsp_tags.delete(0);
                        r.fwd_valid = 1'b1;
                        r.fwd_dir   = 1'b1;
                        if (outstanding == 0)
                            r.unmatched = 1'b1;
                        else
                            outstanding--;
                        r.retry_up = release_retry();
                    end else begin
                        up_wait = 1'b1;
                    end
                end
            end
            iol_pkg::CMD_RSP_RETRY: up_wait = 1'b0;
            default: ;
        endcase
        r.outstanding = outstanding;
        r.req_fill    = 5'(req_tags.size());
        r.rsp_fill    = 5'(rsp_tags.size());
        return r;
    endfunction

    function automatic void queue_item(logic [2:0] cmd, logic [TAG_W-1:0] tag, logic ready);
        t_ingress_item it;
        it.cmd   = cmd;
        it.tag   = tag;
        it.ready = ready;
        items_to_send.insert(items_to_send.size(), it);
    endfunction

    // weighted mix that keeps requests and responses flowing
    function automatic void queue_random_item();
        int pick;
        logic [2:0] cmd;
        pick = $urandom_range(99);
        if (pick < 25)      cmd = iol_pkg::CMD_REQ_IN;
        else if (pick < 45) cmd = iol_pkg::CMD_REQ_FWD;
        else if (pick < 52) cmd = iol_pkg::CMD_REQ_RETRY;
        else if (pick < 72) cmd = iol_pkg::CMD_RSP_IN;
        else if (pick < 88) cmd = iol_pkg::CMD_RSP_FWD;
        else if (pick < 95) cmd = iol_pkg::CMD_RSP_RETRY;
        else if (pick < 97) cmd = CMD_SPARE_6;
        else                cmd = CMD_SPARE_7;
        queue_item(cmd, TAG_W'($urandom_range(65535)), $urandom_range(3) != 0);
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                results_due.insert(results_due.size(), limiter_outcome(cur_item));
                items_sent++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (items_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    cur_item = items_to_send[0];
                    items_to_send.delete(0);
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= IN_DATA_W'({cur_item.ready, cur_item.tag});
                    i_s_axis_tuser  <= cur_item.cmd;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (results_due.size() == 0) begin
                $error("result item with no expectation: data %0h", o_m_axis_tdata);
                fail_count++;
            end else begin
                e = results_due[0];
                results_due.delete(0);
                check_field("accepted", 32'(e.accepted), 32'(o_m_axis_tdata[0]));
                check_field("forward_valid", 32'(e.fwd_valid), 32'(o_m_axis_tdata[1]));
                check_field("forward_tag", 32'(e.fwd_tag), 32'(o_m_axis_tdata[17:2]));
                check_field("retry_upstream", 32'(e.retry_up), 32'(o_m_axis_tdata[18]));
                check_field("unmatched_response", 32'(e.unmatched),
                            32'(o_m_axis_tdata[19]));
                check_field("outstanding_now", 32'(e.outstanding),
                            32'(o_m_axis_tdata[27:20]));
                check_field("request_fill", 32'(e.req_fill), 32'(o_m_axis_tdata[32:28]));
                check_field("response_fill", 32'(e.rsp_fill), 32'(o_m_axis_tdata[37:33]));
                check_field("forward_direction", 32'(e.fwd_dir), 32'(o_m_axis_tuser[0]));
                results_checked++;
                if (e.retry_up) retries_seen++;
                if (e.unmatched) unmatched_seen++;
                if (!e.accepted && (o_m_axis_tdata[0] == 1'b0)) refusals_seen++;
            end
        end
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(logic idx, logic [iol_pkg::LIMIT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == iol_pkg::CFG_LIMIT)
            limit_reg = value;
        else
            depth_reg = value[iol_pkg::DEPTH_W-1:0];
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (items_to_send.size() != 0 || i_s_axis_tvalid || results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_directed();
        // forwards on empty fifos and unused commands
        queue_item(iol_pkg::CMD_REQ_FWD, 16'h0000, 1'b1);
        queue_item(iol_pkg::CMD_RSP_FWD, 16'h0000, 1'b1);
        queue_item(CMD_SPARE_6, 16'hFFFF, 1'b1);
        queue_item(CMD_SPARE_7, 16'h1234, 1'b0);
        // response side: wait flag, blocked forward, retry, unmatched response
        queue_item(iol_pkg::CMD_RSP_IN, 16'hFFFF, 1'b0);
        queue_item(iol_pkg::CMD_RSP_FWD, 16'h0000, 1'b0);
        queue_item(iol_pkg::CMD_RSP_FWD, 16'h0000, 1'b1);
        queue_item(iol_pkg::CMD_RSP_RETRY, 16'h0000, 1'b0);
        queue_item(iol_pkg::CMD_RSP_FWD, 16'h0000, 1'b1);
        // request side: wait flag, blocked forward, retry, pops
        queue_item(iol_pkg::CMD_REQ_IN, 16'h0000, 1'b0);
        queue_item(iol_pkg::CMD_REQ_IN, 16'hFFFF, 1'b1);
        queue_item(iol_pkg::CMD_REQ_FWD, 16'h0000, 1'b0);
        queue_item(iol_pkg::CMD_REQ_FWD, 16'h0000, 1'b1);
        queue_item(iol_pkg::CMD_REQ_RETRY, 16'hFFFF, 1'b1);
        queue_item(iol_pkg::CMD_REQ_FWD, 16'h0000, 1'b1);
        queue_item(iol_pkg::CMD_REQ_FWD, 16'h0000, 1'b1);
        // matched responses lower the count
        queue_item(iol_pkg::CMD_RSP_IN, 16'h5A5A, 1'b1);
        queue_item(iol_pkg::CMD_RSP_FWD, 16'h0000, 1'b1);
        queue_item(iol_pkg::CMD_RSP_IN, 16'hA5A5, 1'b0);
        queue_item(iol_pkg::CMD_RSP_FWD, 16'hFFFF, 1'b1);
        queue_item(iol_pkg::CMD_REQ_IN, 16'hA5A5, 1'b1);
        queue_item(CMD_SPARE_7, 16'hFFFF, 1'b1);
    endtask

    task automatic load_saturation(int n);
        // clear wait flags and drain both fifos first
        queue_item(iol_pkg::CMD_REQ_RETRY, 16'h0000, 1'b0);
        queue_item(iol_pkg::CMD_RSP_RETRY, 16'h0000, 1'b0);
        repeat (BUILT_DEPTH) queue_item(iol_pkg::CMD_REQ_FWD, 16'h0000, 1'b1);
        repeat (BUILT_DEPTH) queue_item(iol_pkg::CMD_RSP_FWD, 16'h0000, 1'b1);
        // push the count up to the limit
        repeat (n) begin
            queue_item(iol_pkg::CMD_REQ_IN, TAG_W'($urandom_range(65535)), 1'b0);
            queue_item(iol_pkg::CMD_REQ_FWD, 16'h0000, 1'b1);
        end
        // refused at the limit, then one response frees a slot for the owed retry
        queue_item(iol_pkg::CMD_REQ_IN, 16'hFFFF, 1'b0);
        queue_item(iol_pkg::CMD_RSP_IN, TAG_W'($urandom_range(65535)), 1'b0);
        queue_item(iol_pkg::CMD_RSP_FWD, 16'h0000, 1'b1);
        queue_item(iol_pkg::CMD_REQ_IN, 16'h0F0F, 1'b0);
    endtask

    task automatic run_phase(t_phase_kind kind, logic [iol_pkg::LIMIT_W-1:0] limit_v,
                             logic [iol_pkg::LIMIT_W-1:0] depth_v, int n);
        // idle mode rotates with the phase number
        case (phases_run % 4)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 57; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 57; end
            default: begin sender_idle_pct = 17; recv_stall_pct = 17; end
        endcase
        if (kind != PH_DIRECTED) begin
            write_reg(iol_pkg::CFG_LIMIT, limit_v);
            write_reg(iol_pkg::CFG_DEPTH, depth_v);
        end
        case (kind)
            PH_DIRECTED: load_directed();
            PH_RANDOM:   repeat (n) queue_random_item();
            PH_FILL: begin
                repeat (n) begin
                    queue_item(($urandom_range(1) != 0) ? iol_pkg::CMD_REQ_IN
                                                        : iol_pkg::CMD_RSP_IN,
                               TAG_W'($urandom_range(65535)), 1'($urandom_range(1)));
                end
            end
            default:     load_saturation(n);
        endcase
        wait_drained();
        phases_run++;
    endtask

    // main sequence
    initial begin
        reset_limiter_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_phase(PH_DIRECTED, iol_pkg::LIMIT_RESET,
                  iol_pkg::LIMIT_W'(iol_pkg::DEPTH_RESET), 0);
        run_phase(PH_RANDOM, 8'd4, 8'd4, 100);
        run_phase(PH_RANDOM, 8'd1, 8'd1, 80);
        run_phase(PH_RANDOM, 8'd0, 8'd0, 30);
        run_phase(PH_RANDOM, 8'd255, 8'd31, 110);
        run_phase(PH_FILL, 8'd255, 8'd16, 24);
        // depth drops below the fill left by the previous phase
        run_phase(PH_RANDOM, 8'd20, 8'd2, 90);
        run_phase(PH_RANDOM, 8'd16, 8'd17, 70);
        run_phase(PH_SATURATE, 8'd24, 8'd16, 30);

        $display("covered %0d items in %0d phases, %0d results checked", items_sent,
                 phases_run, results_checked);
        $display("seen %0d upstream retries, %0d unmatched responses, %0d non-accepting items",
                 retries_seen, unmatched_seen, refusals_seen);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // run time limit
    initial begin
        #5ms;
        $display("timeout: %0d results still expected", results_due.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/iol_pkg.sv
rtl/iol_front.sv
rtl/iol_tag_fifo.sv
rtl/iol_back.sv
rtl/ingress_outstanding_limiter.sv
tb/ingress_outstanding_limiter_tb.sv
